// ===== rtl/core/assert_macros.svh =====
// assertion macros included by bounded_deque_remove_matching
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_IMPLIES_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bdq_pkg.sv =====
// types and codes of the bounded deque request and response beats
`default_nettype none

package bdq_pkg;

   localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
   localparam logic [2:0] OP_READ_FWD   = 3'd2;
   localparam logic [2:0] OP_READ_REV   = 3'd3;
   localparam logic [2:0] OP_REMOVE     = 3'd4;
   localparam logic [2:0] OP_CLEAR      = 3'd5;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] data;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/core/bounded_deque_remove_matching.sv =====
// bounded double-ended queue with ordered remove of matching values
//
// Requests arrive on the req_ channel (valid/ready) as one beat each; every
// request except an unused operation code gives one or more beats on the rsp_
// channel, the final one marked by last. One request is handled at a time:
// req_ready is high only while the block is idle.
// Values live in a single-port memory with registered read, addressed through
// one shared position adder (front plus offset, modulo DEPTH); that memory
// port sets the steps of each request:
//   push front/back, clear, any request on an empty list: rsp beat valid
//     in the cycle after the req beat
//   read forward/reverse: one beat per stored element, each through an
//     address, a data and a response step
//   remove matching: fetch and compare per stored element, one response beat
// Each response waits in an output register until rsp_ready; a stall only
// holds that beat and the sequencer behind it.
// Synchronous active-high reset empties the list and drops any pending beat;
// memory contents are not cleared, so no clearing pass is needed.
`default_nettype none

module bounded_deque_remove_matching #(
   parameter int DEPTH = 64
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire bdq_pkg::req_type req_payload,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      bdq_pkg::rsp_type rsp_payload
);

`include "assert_macros.svh"

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);
   localparam logic [AW-1:0] LAST_OFF  = AW'(DEPTH - 1);

   typedef enum logic [6:0] {
      S_IDLE     = 7'b0000001,
      S_RD_FETCH = 7'b0000010,
      S_RD_DATA  = 7'b0000100,
      S_RD_SEND  = 7'b0001000,
      S_RM_FETCH = 7'b0010000,
      S_RM_CMP   = 7'b0100000,
      S_RM_DONE  = 7'b1000000
   } state_type;

   localparam state_type S_SEND_CODE = S_RD_SEND;

   state_type        state_ff, state_in;
   logic [AW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    i_ff, i_in;
   logic [CW-1:0]    w_ff, w_in;
   logic [AW-1:0]    off_ff, off_in;
   logic             rev_ff, rev_in;
   logic [31:0]      value_ff, value_in;
   logic             rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type rsp_ff, rsp_in;
   logic             single_ff, single_in;

   logic [31:0]      entries_ff [DEPTH];
   logic [31:0]      mem_rd_ff;
   logic             mem_we;
   logic [31:0]      mem_wdata;

   logic [AW-1:0]    slot_off;
   logic [AW:0]      slot_sum;
   logic [AW-1:0]    slot_addr;

   // shared position unit
   always_comb begin
      slot_off = off_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_payload.operation == bdq_pkg::OP_PUSH_FRONT) begin
               slot_off = LAST_OFF;
            end else begin
               slot_off = count_ff[AW-1:0];
            end
         end
         S_RM_FETCH: slot_off = i_ff[AW-1:0];
         S_RM_CMP:   slot_off = w_ff[AW-1:0];
         default:    slot_off = off_ff;
      endcase
      slot_sum = {1'b0, front_ff} + {1'b0, slot_off};
      if (slot_sum >= DEPTH_SUM) begin
         slot_addr = AW'(slot_sum - DEPTH_SUM);
      end else begin
         slot_addr = slot_sum[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entries_ff[slot_addr] <= mem_wdata;
      end
      mem_rd_ff <= entries_ff[slot_addr];
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      front_in     = front_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      w_in         = w_ff;
      off_in       = off_ff;
      rev_in       = rev_ff;
      value_in     = value_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      single_in    = single_ff;
      mem_we       = 1'b0;
      mem_wdata    = req_payload.value;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               value_in      = req_payload.value;
               i_in          = '0;
               w_in          = '0;
               rsp_in.data   = '0;
               rsp_in.status = bdq_pkg::ST_OK;
               rsp_in.last   = 1'b1;
               single_in     = 1'b1;
               case (req_payload.operation) inside
                  bdq_pkg::OP_PUSH_FRONT, bdq_pkg::OP_PUSH_BACK: begin
                     if (count_ff == DEPTH_CNT) begin
                        rsp_in.status = bdq_pkg::ST_FULL;
                     end else begin
                        mem_we   = 1'b1;
                        count_in = count_ff + CW'(1);
                        if (req_payload.operation == bdq_pkg::OP_PUSH_FRONT) begin
                           front_in = slot_addr;
                        end
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_SEND_CODE;
                  end
                  bdq_pkg::OP_READ_FWD, bdq_pkg::OP_READ_REV: begin
                     if (count_ff == '0) begin
                        rsp_in.status = bdq_pkg::ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_SEND_CODE;
                     end else begin
                        rev_in    = (req_payload.operation == bdq_pkg::OP_READ_REV);
                        off_in    = (req_payload.operation == bdq_pkg::OP_READ_REV) ?
                                    AW'(count_ff - CW'(1)) : '0;
                        single_in = 1'b0;
                        state_in  = S_RD_FETCH;
                     end
                  end
                  bdq_pkg::OP_REMOVE: begin
                     if (count_ff == '0) begin
                        rsp_in.status = bdq_pkg::ST_EMPTY;
                        rsp_valid_in  = 1'b1;
                        state_in      = S_SEND_CODE;
                     end else begin
                        state_in = S_RM_FETCH;
                     end
                  end
                  bdq_pkg::OP_CLEAR: begin
                     if (count_ff == '0) begin
                        rsp_in.status = bdq_pkg::ST_EMPTY;
                     end else begin
                        count_in = '0;
                        front_in = '0;
                     end
                     rsp_valid_in = 1'b1;
                     state_in     = S_SEND_CODE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RD_FETCH: begin
            state_in = S_RD_DATA;
         end
         S_RD_DATA: begin
            rsp_in.data   = mem_rd_ff;
            rsp_in.status = bdq_pkg::ST_OK;
            rsp_in.last   = ((i_ff + CW'(1)) == count_ff);
            rsp_valid_in  = 1'b1;
            state_in      = S_RD_SEND;
         end
         S_RD_SEND: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last || single_ff) begin
                  state_in = S_IDLE;
               end else begin
                  i_in     = i_ff + CW'(1);
                  off_in   = rev_ff ? (off_ff - AW'(1)) : (off_ff + AW'(1));
                  state_in = S_RD_FETCH;
               end
            end
         end
         S_RM_FETCH: begin
            state_in = S_RM_CMP;
         end
         S_RM_CMP: begin
            if (mem_rd_ff != value_ff) begin
               mem_we    = 1'b1;
               mem_wdata = mem_rd_ff;
               w_in      = w_ff + CW'(1);
            end
            i_in     = i_ff + CW'(1);
            state_in = ((i_ff + CW'(1)) == count_ff) ? S_RM_DONE : S_RM_FETCH;
         end
         S_RM_DONE: begin
            count_in = w_ff;
            if (w_ff == '0) begin
               front_in = '0;
            end
            rsp_in.data   = 32'(count_ff - w_ff);
            rsp_in.status = bdq_pkg::ST_OK;
            rsp_in.last   = 1'b1;
            rsp_valid_in  = 1'b1;
            single_in     = 1'b1;
            state_in      = S_SEND_CODE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      w_ff      <= w_in;
      off_ff    <= off_in;
      rev_ff    <= rev_in;
      value_ff  <= value_in;
      rsp_ff    <= rsp_in;
      single_ff <= single_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_CNT, "entry count above depth")
   `ASSERT_ALWAYS(a_no_overlap, clock, reset, !(req_ready && rsp_valid), "ready while beat pending")
   `ASSERT_IMPLIES(a_compact_order, clock, reset, state_ff == S_RM_CMP, w_ff <= i_ff, "write passed read")
   `ASSERT_IMPLIES_NEXT(a_last_idle, clock, reset, rsp_valid && rsp_ready && rsp_payload.last, req_ready, "no idle after last beat")

endmodule

`default_nettype wire
